### rtl/core/x86ild_pkg.sv
// Shared types, opcode constants and prefix classification for the x86
// instruction length decoder. No dependencies.
`default_nettype none

package x86ild_pkg;

    localparam int WINDOW_BYTES = 16;
    // Lanes cannot exceed the 16 bytes the input item carries.
    localparam int NUM_LANES    = (WINDOW_BYTES < 16) ? WINDOW_BYTES : 16;
    localparam int SEL_W        = $clog2(NUM_LANES);
    localparam int LIM_W        = 5;
    localparam int LEN_W        = 5;
    localparam int REL_LEN_W    = 4;
    localparam int LANE_WIN     = 8;
    localparam int IN_DATA_W    = 136;
    localparam int OUT_DATA_W   = 8;

    localparam logic [7:0] OP_OPSIZE   = 8'h66;
    localparam logic [7:0] OP_ADDRSIZE = 8'h67;
    localparam logic [7:0] OP_LOCK     = 8'hF0;
    localparam logic [7:0] OP_REPNE    = 8'hF2;
    localparam logic [7:0] OP_REP      = 8'hF3;
    localparam logic [7:0] OP_ESCAPE   = 8'h0F;
    localparam logic [7:0] OP_CALL     = 8'hE8;
    localparam logic [7:0] OP_JMP32    = 8'hE9;
    localparam logic [7:0] OP_JMP8     = 8'hEB;
    localparam logic [7:0] OP_GRP5     = 8'hFF;
    localparam logic [7:0] OP_MOV_RM8  = 8'h88;
    localparam logic [7:0] OP_MOV_RM   = 8'h89;
    localparam logic [7:0] OP_MOV_R8   = 8'h8A;
    localparam logic [7:0] OP_MOV_R    = 8'h8B;
    localparam logic [7:0] OP_ALU_IB   = 8'h80;
    localparam logic [7:0] OP_ALU_IZ   = 8'h81;
    localparam logic [7:0] OP_ALU_IBS  = 8'h83;
    localparam logic [7:0] OP_MOV_IZ   = 8'hC7;
    localparam logic [7:0] OP_LEA      = 8'h8D;
    localparam logic [7:0] OP_DISP32   = 8'h25;

    typedef struct packed {
        logic                 prefix;
        logic                 ok;
        logic                 rel;
        logic [REL_LEN_W-1:0] len;
    } lane_res_t;

    function automatic logic is_prefix(input logic [7:0] b, input logic lm);
        return (b == OP_OPSIZE) || (b == OP_ADDRSIZE) || (b == OP_LOCK) ||
               (b == OP_REPNE) || (b == OP_REP) || (lm && b[7:4] == 4'h4);
    endfunction

    function automatic logic is_rexw(input logic [7:0] b, input logic lm);
        return lm && (b[7:3] == 5'b01001);
    endfunction

endpackage

`default_nettype wire

### rtl/core/x86_instruction_length_decode.sv
// Top level of the x86 instruction length decoder: prefix scan, decode
// lanes, merge and output register. Uses x86ild_pkg, x86ild_lane, x86ild_merge.
// m_tvalid rises in the cycle after an item is accepted.
// Throughput: 1 item per cycle while m_tready is high; lanes and merge sit in
//   one stage ahead of the output register. A result held with m_tready low
//   drops s_tready until it is taken.
// Reset: rst_n async active low clears m_tvalid and sets long_mode to 1.
`default_nettype none

module x86_instruction_length_decode
    import x86ild_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic                  cfg_wr_data,   // long_mode
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,       // bytes_lo, bytes_hi, valid_count
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [OUT_DATA_W-1:0] m_tdata        // insn_length, is_branch_rel, failed
);

    localparam int NUM_BYTES = NUM_LANES + LANE_WIN - 1;

    logic                  long_mode_reg;
    logic                  out_valid_reg;
    logic [LEN_W-1:0]      len_reg;
    logic                  rel_reg;
    logic                  fail_reg;

    logic [127:0]          code;
    logic [LIM_W-1:0]      cnt;
    logic [LIM_W-1:0]      lim;
    logic [7:0]            code_byte [NUM_BYTES];
    logic [NUM_LANES-1:0]  is66_vec;
    logic [NUM_LANES-1:0]  rexw_vec;
    logic [NUM_LANES-1:0]  has66;
    logic [NUM_LANES-1:0]  rexw;
    lane_res_t             lane_res [NUM_LANES];
    logic [LEN_W-1:0]      len_next;
    logic                  rel_next;
    logic                  fail_next;

    assign code = s_tdata[127:0];
    assign cnt  = s_tdata[132:128];
    assign lim  = (cnt > LIM_W'(NUM_LANES)) ? LIM_W'(NUM_LANES) : cnt;

    always_comb
    begin
        for (int k = 0; k < NUM_BYTES; k++)
        begin
            code_byte[k] = (k < 16) ? code[8*(k%16) +: 8] : 8'h00;
        end
        for (int i = 0; i < NUM_LANES; i++)
        begin
            is66_vec[i] = (code_byte[i] == OP_OPSIZE);
            rexw_vec[i] = is_rexw(code_byte[i], long_mode_reg);
        end
        // a lane is picked only when every byte below it is a prefix
        for (int i = 0; i < NUM_LANES; i++)
        begin
            has66[i] = 1'b0;
            rexw[i]  = 1'b0;
            for (int j = 0; j < NUM_LANES; j++)
            begin
                if (j < i)
                begin
                    has66[i] = has66[i] | is66_vec[j];
                    rexw[i]  = rexw[i] | rexw_vec[j];
                end
            end
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        logic [8*LANE_WIN-1:0] win;
        logic [LIM_W-1:0]      rem;

        always_comb
        begin
            for (int j = 0; j < LANE_WIN; j++)
            begin
                win[8*j +: 8] = code_byte[g + j];
            end
        end

        assign rem = lim - LIM_W'(g);

        x86ild_lane u_lane (
            .win       (win),
            .rem       (rem),
            .long_mode (long_mode_reg),
            .has66     (has66[g]),
            .rexw      (rexw[g]),
            .res       (lane_res[g])
        );
    end

    x86ild_merge u_merge (
        .lane_res      (lane_res),
        .lim           (lim),
        .insn_length   (len_next),
        .is_branch_rel (rel_next),
        .failed        (fail_next)
    );

    assign s_tready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_mode_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                long_mode_reg <= cfg_wr_data;
            if (s_tready)
                out_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            len_reg  <= len_next;
            rel_reg  <= rel_next;
            fail_reg <= fail_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, fail_reg, rel_reg, len_reg};

endmodule

`default_nettype wire

### rtl/core/x86ild_lane.sv
// One decode lane: assumes the opcode sits at its own byte position and
// finds length, branch flag and window check. Uses x86ild_pkg.
`default_nettype none

module x86ild_lane
    import x86ild_pkg::*;
(
    input  wire logic [8*LANE_WIN-1:0] win,
    input  wire logic [LIM_W-1:0]      rem,
    input  wire logic                  long_mode,
    input  wire logic                  has66,
    input  wire logic                  rexw,
    output lane_res_t                  res
);

    logic [7:0]           b0;
    logic [7:0]           b1;
    logic [7:0]           b2;
    logic [1:0]           md;
    logic [2:0]           rm;
    logic                 sib;
    logic [REL_LEN_W-1:0] ml;
    logic [REL_LEN_W-1:0] mov_len;
    logic                 m_ok;
    logic                 mov_ok;
    logic                 mov_reg4;
    logic [7:0]           tail_byte;

    assign b0 = win[7:0];
    assign b1 = win[15:8];
    assign b2 = win[23:16];
    assign md = b1[7:6];
    assign rm = b1[2:0];

    // ModRM + SIB + displacement, opcode included
    always_comb
    begin
        sib = (rm == 3'd4) && (md != 2'd3);
        ml  = REL_LEN_W'(2) + REL_LEN_W'(sib);
        if (md == 2'd0 && rm == 3'd5)
            ml = ml + REL_LEN_W'(4);
        else if (md == 2'd1)
            ml = ml + REL_LEN_W'(1);
        else if (md == 2'd2)
            ml = ml + REL_LEN_W'(4);
        m_ok = (rem > LIM_W'(1)) && (!sib || rem > LIM_W'(2));
    end

    // mov with reg field 4: a disp32 marker may follow the addressing bytes
    always_comb
    begin
        mov_reg4  = (b1[5:3] == 3'd4) && ((b0 == OP_MOV_RM) || (b0 == OP_MOV_R));
        tail_byte = win[8*ml[2:0] +: 8];
        mov_len   = ml;
        mov_ok    = m_ok;
        if (mov_reg4)
        begin
            if (LIM_W'(ml) >= rem)
                mov_ok = 1'b0;
            else if (tail_byte == OP_DISP32)
                mov_len = ml + REL_LEN_W'(5);
        end
        if (LIM_W'(mov_len) > rem)
            mov_ok = 1'b0;
    end

    always_comb
    begin
        res.prefix = is_prefix(b0, long_mode);
        res.ok     = 1'b0;
        res.rel    = 1'b0;
        res.len    = '0;
        if (long_mode && rexw && b0[7:3] == 5'b10111)
        begin
            res.len = REL_LEN_W'(9);
            res.ok  = rem >= LIM_W'(9);
        end
        else
        begin
            case (b0) inside
                [8'h70:8'h7F], OP_JMP8:
                begin
                    res.len = REL_LEN_W'(2);
                    res.ok  = rem >= LIM_W'(2);
                    res.rel = 1'b1;
                end
                OP_CALL, OP_JMP32:
                begin
                    res.len = REL_LEN_W'(5);
                    res.ok  = rem >= LIM_W'(5);
                    res.rel = 1'b1;
                end
                OP_ESCAPE:
                begin
                    if (rem > LIM_W'(1) && b1[7:4] == 4'h8)
                    begin
                        res.len = REL_LEN_W'(6);
                        res.ok  = rem >= LIM_W'(6);
                        res.rel = 1'b1;
                    end
                    else
                    begin
                        res.len = REL_LEN_W'(1);
                        res.ok  = 1'b1;
                    end
                end
                OP_GRP5:
                begin
                    // no window check on the tail, only on ModRM and SIB
                    if (rem > LIM_W'(1))
                    begin
                        res.ok = 1'b1;
                        if (md == 2'd0 && rm == 3'd5)
                            res.len = REL_LEN_W'(6);
                        else if (md == 2'd1)
                            res.len = REL_LEN_W'(3);
                        else if (md == 2'd2)
                            res.len = REL_LEN_W'(6);
                        else if (md == 2'd3)
                            res.len = REL_LEN_W'(2);
                        else if (rm == 3'd4)
                        begin
                            if (rem > LIM_W'(2))
                                res.len = (b2[2:0] == 3'd5) ? REL_LEN_W'(7) : REL_LEN_W'(3);
                            else
                                res.ok = 1'b0;
                        end
                        else
                            res.len = REL_LEN_W'(2);
                    end
                end
                OP_MOV_RM8, OP_MOV_RM, OP_MOV_R8, OP_MOV_R:
                begin
                    res.len = mov_len;
                    res.ok  = mov_ok;
                end
                OP_ALU_IB, OP_ALU_IBS:
                begin
                    res.len = ml + REL_LEN_W'(1);
                    res.ok  = m_ok && (LIM_W'(res.len) <= rem);
                end
                OP_ALU_IZ, OP_MOV_IZ:
                begin
                    res.len = ml + (has66 ? REL_LEN_W'(2) : REL_LEN_W'(4));
                    res.ok  = m_ok && (LIM_W'(res.len) <= rem);
                end
                OP_LEA:
                begin
                    res.len = ml;
                    res.ok  = m_ok && (LIM_W'(ml) <= rem);
                end
                default:
                begin
                    res.len = REL_LEN_W'(1);
                    res.ok  = 1'b1;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/core/x86ild_merge.sv
// Merge stage: picks the first non-prefix lane inside the window and forms
// the absolute length and flags. Uses x86ild_pkg.
`default_nettype none

module x86ild_merge
    import x86ild_pkg::*;
(
    input  wire lane_res_t         lane_res [NUM_LANES],
    input  wire logic [LIM_W-1:0]  lim,
    output logic      [LEN_W-1:0]  insn_length,
    output logic                   is_branch_rel,
    output logic                   failed
);

    logic             found;
    logic [SEL_W-1:0] sel;
    lane_res_t        pick;

    always_comb
    begin
        found = 1'b0;
        sel   = '0;
        for (int i = NUM_LANES - 1; i >= 0; i--)
        begin
            if (LIM_W'(i) < lim && !lane_res[i].prefix)
            begin
                found = 1'b1;
                sel   = SEL_W'(i);
            end
        end
        pick = lane_res[sel];
        if (found && pick.ok)
        begin
            insn_length   = LEN_W'(sel) + LEN_W'(pick.len);
            is_branch_rel = pick.rel;
            failed        = 1'b0;
        end
        else
        begin
            // empty window, prefixes only, or instruction runs past the window
            insn_length   = '0;
            is_branch_rel = 1'b0;
            failed        = 1'b1;
        end
    end

endmodule

`default_nettype wire

### rtl/core/x86ild_checker.sv
// Port-level checks for the x86 instruction length decoder, bound to the
// top level. Uses x86ild_pkg.
`default_nettype none

module x86ild_checker
    import x86ild_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [IN_DATA_W-1:0]  s_tdata,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata
);

    logic [LIM_W-1:0] cap_cnt;

    assign cap_cnt = (s_tdata[132:128] > LIM_W'(NUM_LANES)) ? LIM_W'(NUM_LANES)
                                                            : s_tdata[132:128];

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[6] |-> m_tdata[5:0] == 6'd0)
        else $error("failed result carries length or branch flag");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[6] |-> m_tdata[4:0] != 5'd0)
        else $error("good result with zero length");

    a_result_next: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted item gave no result");

    a_empty_fails: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && cap_cnt == 5'd0 |=> m_tdata[6])
        else $error("empty window not marked failed");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind x86_instruction_length_decode x86ild_checker u_x86ild_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
